// ----- design/bcdc_pkg.sv -----
// ============================================================================
// bcdc_pkg: shared types and constants
// Field widths, decimal constants and the item and result structures of the
// debounced BCD counter with multiplexed display.
// ============================================================================
package bcdc_pkg;

    localparam int DIGIT_COUNT_DEF = 4;
    localparam int DIGIT_W         = 4;
    localparam int RADIX           = 10;
    localparam int BCD_TOP         = 9;
    localparam int LIMIT_DIGITS    = 6;

    localparam int PRESET_W        = 14;
    localparam int COUNT_W         = 16;
    localparam int THR_W           = 16;
    localparam int SEG_W           = 8;

    localparam logic [THR_W-1:0] THR_RESET = 16'd3277;

    localparam int S_TDATA_W       = 16;
    localparam int S_TUSER_W       = 1;
    localparam int M_TDATA_W       = 32;

    // One input tick after unpacking from the stream
    typedef struct packed {
        logic                button;
        logic                strobe;
        logic                load;
        logic [PRESET_W-1:0] preset;
    } bcdc_item_t;

    // One result item; segment sits in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               press;
        logic               common;
        logic [SEG_W-1:0]   segment;
    } bcdc_result_t;

    localparam int RESULT_W = $bits(bcdc_result_t);

endpackage

// ----- design/debounced_bcd_counter_display_mux_unit.sv -----
// ============================================================================
// debounced_bcd_counter_display_mux_unit: debounced BCD event counter
// Counts debounced button presses in binary and BCD, loads a stored preset
// and drives a two-phase multiplexed digit display latch.
// ============================================================================
// Dataflow: an accepted item waits in the input register and moves to the
//   result register once the output is free, which raises m_tvalid; the
//   result item is then held until m_tready takes it.
// Throughput: one item per cycle unless m_tready stalls the output; the
//   state update is a single pass of short logic between the two registers.
// Reset: rst_n clears counts, run length, phase, display latch and both
//   valid flags at once, and restores the debounce threshold to 3277.
module debounced_bcd_counter_display_mux_unit #(
    parameter int DIGIT_COUNT = bcdc_pkg::DIGIT_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input item stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bcdc_pkg::S_TDATA_W-1:0]   s_tdata,   // button_level, mux_strobe,
                                                        // preset_value[13:0]
    input  logic [bcdc_pkg::S_TUSER_W-1:0]   s_tuser,   // load_preset
    // Result item stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bcdc_pkg::M_TDATA_W-1:0]   m_tdata,   // segment_byte[7:0],
                                                        // common_select,
                                                        // press_accepted,
                                                        // count_binary[15:0], zeros
    // Debounce threshold register
    input  logic                             cfg_we,
    input  logic [bcdc_pkg::THR_W-1:0]       cfg_wdata
);

    logic                      in_valid_reg, in_valid_next;
    bcdc_pkg::bcdc_item_t      in_item_reg;
    bcdc_pkg::bcdc_item_t      s_item;
    logic                      out_valid_reg, out_valid_next;
    bcdc_pkg::bcdc_result_t    out_data_reg;
    bcdc_pkg::bcdc_result_t    step_result;

    logic [DIGIT_COUNT-1:0][bcdc_pkg::DIGIT_W-1:0] preset_digits;

    logic                      s_accept;
    logic                      out_free;
    logic                      fire;

    // Unpack the incoming item
    assign s_item.button = s_tdata[0];
    assign s_item.strobe = s_tdata[1];
    assign s_item.preset = s_tdata[2 +: bcdc_pkg::PRESET_W];
    assign s_item.load   = s_tuser[0];

    // The result register frees when empty or being drained this cycle;
    // the input register then advances its item into it.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold until the next transfer
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= s_item;
        end
        if (fire)
        begin
            out_data_reg <= step_result;
        end
    end

    // Decimal split of the preset, used only when the item loads it
    bcdc_preset_split #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_split (
        .preset_value (in_item_reg.preset),
        .digits       (preset_digits)
    );

    // Counter state and the per-tick update
    bcdc_step #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fire          (fire),
        .item          (in_item_reg),
        .preset_digits (preset_digits),
        .result        (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bcdc_pkg::M_TDATA_W - bcdc_pkg::RESULT_W){1'b0}}, out_data_reg};

`ifndef SYNTH
    // An empty input stage always takes a new item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // A processed item always shows up as a result
    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed item produced no result");

    // A waiting item is neither dropped nor altered
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("pending item lost or changed");

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && out_valid_reg && !m_tready))
        else $error("stalled result overwritten");
`endif

endmodule

// ----- design/bcdc_preset_split.sv -----
// ============================================================================
// bcdc_preset_split: binary preset to BCD digits
// Splits the preset into decimal digits with reciprocal multiplies, one per
// digit position, and saturates to all nines above the display range.
// ============================================================================
module bcdc_preset_split #(
    parameter int DIGIT_COUNT = bcdc_pkg::DIGIT_COUNT_DEF
) (
    input  logic [bcdc_pkg::PRESET_W-1:0]                  preset_value,
    output logic [DIGIT_COUNT-1:0][bcdc_pkg::DIGIT_W-1:0]  digits
);

    localparam int PW_IN     = bcdc_pkg::PRESET_W;
    localparam int LimDigits = (DIGIT_COUNT < bcdc_pkg::LIMIT_DIGITS) ?
                               DIGIT_COUNT : bcdc_pkg::LIMIT_DIGITS;
    localparam longint unsigned Limit = longint'(bcdc_pkg::RADIX) ** LimDigits;

    logic [DIGIT_COUNT-1:0][PW_IN-1:0]            quot;
    logic [DIGIT_COUNT-1:0][bcdc_pkg::DIGIT_W-1:0] split;
    logic                                          over;

    // quot[k] = preset / 10^k, each by its own exact reciprocal
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_quot
        localparam longint unsigned Div = longint'(bcdc_pkg::RADIX) ** k;
        localparam int              Sh  = PW_IN + $clog2(Div);
        localparam longint unsigned Mul = ((64'd1 << Sh) + Div - 64'd1) / Div;
        localparam int              PW  = PW_IN + Sh + 1;

        logic [PW-1:0] prod;

        assign prod    = PW'(preset_value) * PW'(Mul);
        assign quot[k] = prod[Sh +: PW_IN];
    end

    // digit k = quot[k] - 10 * quot[k+1]; top digit keeps the rest
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
        if (k < DIGIT_COUNT - 1) begin : g_low
            logic [PW_IN-1:0] diff;

            assign diff     = quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1));
            assign split[k] = diff[bcdc_pkg::DIGIT_W-1:0];
        end else begin : g_top
            assign split[k] = quot[k][bcdc_pkg::DIGIT_W-1:0];
        end
    end

    assign over = 64'(preset_value) >= Limit;

    always_comb
    begin
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            digits[k] = over ? bcdc_pkg::DIGIT_W'(bcdc_pkg::BCD_TOP) : split[k];
        end
    end

endmodule

// ----- design/bcdc_step.sv -----
// ============================================================================
// bcdc_step: counter state and per-tick update
// Holds the debounce run, binary and BCD counts and display phase/latch, and
// works out the next state and result for the item in the input register.
// ============================================================================
module bcdc_step #(
    parameter int DIGIT_COUNT = bcdc_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [bcdc_pkg::THR_W-1:0]                    cfg_wdata,
    input  logic                                          fire,
    input  bcdc_pkg::bcdc_item_t                          item,
    input  logic [DIGIT_COUNT-1:0][bcdc_pkg::DIGIT_W-1:0] preset_digits,
    output bcdc_pkg::bcdc_result_t                        result
);

    localparam int DW = bcdc_pkg::DIGIT_W;

    logic [bcdc_pkg::THR_W-1:0]        thr_reg;
    logic [bcdc_pkg::THR_W-1:0]        run_reg,   run_next;
    logic [bcdc_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [DIGIT_COUNT-1:0][DW-1:0]    digits_reg, digits_next;
    logic                              phase_reg, phase_next;
    logic [bcdc_pkg::SEG_W-1:0]        latch_reg, latch_next;

    logic [bcdc_pkg::COUNT_W-1:0]      count_load;
    logic [DIGIT_COUNT-1:0][DW-1:0]    digits_load;
    logic [bcdc_pkg::THR_W-1:0]        run_inc;
    logic                              press;
    logic [DIGIT_COUNT-1:0]            carry;
    logic [DW-1:0]                     hi0, hi1, lo, hi;

    assign count_load  = item.load ? bcdc_pkg::COUNT_W'(item.preset) : count_reg;
    assign digits_load = item.load ? preset_digits : digits_reg;

    // Debounce: extend the run, count on reaching the threshold
    assign run_inc    = run_reg + 1'b1;
    assign press      = item.button && (run_inc == thr_reg);
    assign run_next   = (item.button && !press) ? run_inc : '0;
    assign count_next = press ? count_load + 1'b1 : count_load;

    // Decimal ripple increment
    assign carry[0] = press;
    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_bump
        logic [DW-1:0] inc;
        logic          wrap;

        assign inc  = digits_load[k] + 1'b1;
        assign wrap = inc >= DW'(bcdc_pkg::RADIX);
        assign digits_next[k] = carry[k] ? (wrap ? '0 : inc) : digits_load[k];
        if (k < DIGIT_COUNT - 1) begin : g_carry
            assign carry[k+1] = carry[k] && wrap;
        end
    end

    // Display pair selection; missing digits read as zero
    if (DIGIT_COUNT > 2) begin : g_hi0
        assign hi0 = digits_next[2];
    end else begin : g_no_hi0
        assign hi0 = '0;
    end
    if (DIGIT_COUNT > 3) begin : g_hi1
        assign hi1 = digits_next[3];
    end else begin : g_no_hi1
        assign hi1 = '0;
    end

    assign phase_next = item.strobe ? ~phase_reg : phase_reg;
    assign lo         = phase_next ? digits_next[1] : digits_next[0];
    assign hi         = phase_next ? hi1 : hi0;
    assign latch_next = item.strobe ? {hi, lo} : latch_reg;

    assign result.segment = latch_next;
    assign result.common  = phase_next;
    assign result.press   = press;
    assign result.count   = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= bcdc_pkg::THR_RESET;
            run_reg    <= '0;
            count_reg  <= '0;
            digits_reg <= '0;
            phase_reg  <= 1'b0;
            latch_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (fire)
            begin
                run_reg    <= run_next;
                count_reg  <= count_next;
                digits_reg <= digits_next;
                phase_reg  <= phase_next;
                latch_reg  <= latch_next;
            end
        end
    end

endmodule
